FILE: hdl/rtc_pkg.sv
package rtc_pkg;

    // fixed field and register widths
    localparam int SCREEN_W    = 12;
    localparam int POS_W       = 12;
    localparam int PRESS_W     = 12;
    localparam int ORIENT_W    = 3;
    localparam int JIT_W       = 13;
    localparam int LIMIT_W     = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;

    // orientation bits
    localparam int ORIENT_MIRROR_X = 0;
    localparam int ORIENT_MIRROR_Y = 1;
    localparam int ORIENT_SWAP     = 2;

    // register reset values
    localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [ORIENT_W-1:0] RST_ORIENTATION   = 3'd4;
    localparam logic [PRESS_W-1:0]  RST_PRESSURE_MIN  = 12'd500;
    localparam logic [PRESS_W-1:0]  RST_PRESSURE_MAX  = 12'd2000;
    localparam logic [JIT_W-1:0]    RST_JITTER_LIMIT  = 13'd5;
    localparam logic [LIMIT_W-1:0]  RST_REPORT_LIMIT  = 12'd3;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ORIENTATION   = 3'd2,
        REG_PRESSURE_MIN  = 3'd3,
        REG_PRESSURE_MAX  = 3'd4,
        REG_JITTER_LIMIT  = 3'd5,
        REG_REPORT_LIMIT  = 3'd6
    } rtc_reg_t;

    // configuration as seen by the stages
    typedef struct packed {
        logic [SCREEN_W-1:0] screen_width;
        logic [SCREEN_W-1:0] screen_height;
        logic [ORIENT_W-1:0] orientation;
        logic [PRESS_W-1:0]  pressure_min;
        logic [PRESS_W-1:0]  pressure_max;
        logic [JIT_W-1:0]    jitter_limit;
        logic [LIMIT_W-1:0]  report_limit;
    } rtc_cfg_t;

endpackage

FILE: hdl/rtc_filter.sv
module rtc_filter #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [SAMPLE_BITS-1:0] raw_x,
    input  logic [SAMPLE_BITS-1:0] raw_y,
    input  logic [SAMPLE_BITS-1:0] raw_pressure,
    input  rtc_pkg::rtc_cfg_t      cfg,
    output logic                   touched,
    output logic [SAMPLE_BITS:0]   filt_x,
    output logic [SAMPLE_BITS:0]   filt_y
);
    import rtc_pkg::*;

    localparam int PW = (SAMPLE_BITS > PRESS_W) ? SAMPLE_BITS : PRESS_W;
    localparam int AW = SAMPLE_BITS + 1;
    localparam int DW = ((AW + 1) > JIT_W) ? (AW + 1) : JIT_W;
    localparam logic [AW-1:0] FULL_SCALE = {1'b1, {SAMPLE_BITS{1'b0}}};

    logic [PW-1:0] press_ext;
    logic [PW-1:0] pmin_ext;
    logic [PW-1:0] pmax_ext;
    logic [AW-1:0] mir_x;
    logic [AW-1:0] mir_y;
    logic [AW-1:0] smp_x;
    logic [AW-1:0] smp_y;
    logic [AW-1:0] dist_x;
    logic [AW-1:0] dist_y;
    logic [DW-1:0] dist_sum;
    logic          move;
    logic [AW-1:0] filtered_x_reg;
    logic [AW-1:0] filtered_y_reg;

    // touch detect: pressure strictly inside the window
    assign press_ext = PW'(raw_pressure);
    assign pmin_ext  = PW'(cfg.pressure_min);
    assign pmax_ext  = PW'(cfg.pressure_max);
    assign touched   = (press_ext > pmin_ext) && (press_ext < pmax_ext);

    // mirror then swap
    assign mir_x = cfg.orientation[ORIENT_MIRROR_X] ? FULL_SCALE - AW'(raw_x) : AW'(raw_x);
    assign mir_y = cfg.orientation[ORIENT_MIRROR_Y] ? FULL_SCALE - AW'(raw_y) : AW'(raw_y);
    assign smp_x = cfg.orientation[ORIENT_SWAP] ? mir_y : mir_x;
    assign smp_y = cfg.orientation[ORIENT_SWAP] ? mir_x : mir_y;

    // manhattan distance to the held position
    assign dist_x   = (smp_x > filtered_x_reg) ? smp_x - filtered_x_reg : filtered_x_reg - smp_x;
    assign dist_y   = (smp_y > filtered_y_reg) ? smp_y - filtered_y_reg : filtered_y_reg - smp_y;
    assign dist_sum = DW'(dist_x) + DW'(dist_y);
    assign move     = touched && (dist_sum > DW'(cfg.jitter_limit));

    assign filt_x = move ? smp_x : filtered_x_reg;
    assign filt_y = move ? smp_y : filtered_y_reg;

    // held position follows the sample only past the jitter limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filtered_x_reg <= '0;
            filtered_y_reg <= '0;
        end
        else if (advance && move)
        begin
            filtered_x_reg <= smp_x;
            filtered_y_reg <= smp_y;
        end
    end

endmodule

FILE: hdl/rtc_report.sv
module rtc_report #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       touched,
    input  logic [SAMPLE_BITS:0]       filt_x,
    input  logic [SAMPLE_BITS:0]       filt_y,
    input  rtc_pkg::rtc_cfg_t          cfg,
    output logic                       report,
    output logic                       pressed_next,
    output logic [rtc_pkg::POS_W-1:0]  last_x_next,
    output logic [rtc_pkg::POS_W-1:0]  last_y_next
);
    import rtc_pkg::*;

    localparam int AW    = SAMPLE_BITS + 1;
    localparam int PRODW = SCREEN_W + AW;

    logic [PRODW-1:0] prod_x;
    logic [PRODW-1:0] prod_y;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] move_x;
    logic [POS_W-1:0] move_y;
    logic             last_pressed_reg;
    logic [POS_W-1:0] last_x_reg;
    logic [POS_W-1:0] last_y_reg;

    // scale to screen size, position reads zero when untouched
    assign prod_x = PRODW'(cfg.screen_width) * PRODW'(filt_x);
    assign prod_y = PRODW'(cfg.screen_height) * PRODW'(filt_y);
    assign px     = touched ? prod_x[SAMPLE_BITS +: POS_W] : '0;
    assign py     = touched ? prod_y[SAMPLE_BITS +: POS_W] : '0;

    // movement against the last report
    assign move_x = (last_x_reg > px) ? last_x_reg - px : px - last_x_reg;
    assign move_y = (last_y_reg > py) ? last_y_reg - py : py - last_y_reg;
    assign report = (touched != last_pressed_reg)
                 || (move_x > cfg.report_limit)
                 || (move_y > cfg.report_limit);

    // a report with a zero coordinate keeps the old position
    always_comb
    begin
        pressed_next = last_pressed_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        if (report)
        begin
            pressed_next = touched;
            if ((px != '0) && (py != '0))
            begin
                last_x_next = px;
                last_y_next = py;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pressed_reg <= 1'b0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
        end
        else if (advance)
        begin
            last_pressed_reg <= pressed_next;
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
        end
    end

endmodule

FILE: hdl/resistive_touch_conditioner_core.sv
// Resistive touch conditioner: takes one X, Y, pressure sample per request and returns
// exactly one result per request, in order. Throughput is one sample per clock unless the output
// stalls; each sample passes the input register, filter stage and scale/report stage in turn.
// The held filter position lives in the filter stage and the last report in the report
// stage, so a sample only sees state left by the sample just ahead of it in the same stage.
// Stall propagates back through the three registers; empty stages are filled while the
// output is stalled. Configuration registers are written through cfg_write/cfg_index/
// cfg_data and must only be written while no request is in flight.
module resistive_touch_conditioner_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rtc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              raw_x,
    input  logic [SAMPLE_BITS-1:0]              raw_y,
    input  logic [SAMPLE_BITS-1:0]              raw_pressure,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                report_valid,
    output logic                                pressed,
    output logic [rtc_pkg::POS_W-1:0]           pos_x,
    output logic [rtc_pkg::POS_W-1:0]           pos_y
);
    import rtc_pkg::*;

    rtc_cfg_t               cfg_reg;
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_x_reg;
    logic [SAMPLE_BITS-1:0] s1_y_reg;
    logic [SAMPLE_BITS-1:0] s1_p_reg;
    logic                   s2_valid_reg;
    logic                   s2_touched_reg;
    logic [SAMPLE_BITS:0]   s2_x_reg;
    logic [SAMPLE_BITS:0]   s2_y_reg;
    logic                   out_valid_reg;
    logic                   report_valid_reg;
    logic                   pressed_reg;
    logic [POS_W-1:0]       pos_x_reg;
    logic [POS_W-1:0]       pos_y_reg;
    logic                   out_ready;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   s1_fire;
    logic                   s2_fire;
    logic                   in_accept;
    logic                   f_touched;
    logic [SAMPLE_BITS:0]   f_x;
    logic [SAMPLE_BITS:0]   f_y;
    logic                   r_report;
    logic                   r_pressed;
    logic [POS_W-1:0]       r_x;
    logic [POS_W-1:0]       r_y;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.orientation   <= RST_ORIENTATION;
            cfg_reg.pressure_min  <= RST_PRESSURE_MIN;
            cfg_reg.pressure_max  <= RST_PRESSURE_MAX;
            cfg_reg.jitter_limit  <= RST_JITTER_LIMIT;
            cfg_reg.report_limit  <= RST_REPORT_LIMIT;
        end
        else if (cfg_write)
        begin
            case (rtc_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SCREEN_W-1:0];
                REG_ORIENTATION:   cfg_reg.orientation   <= cfg_data[ORIENT_W-1:0];
                REG_PRESSURE_MIN:  cfg_reg.pressure_min  <= cfg_data[PRESS_W-1:0];
                REG_PRESSURE_MAX:  cfg_reg.pressure_max  <= cfg_data[PRESS_W-1:0];
                REG_JITTER_LIMIT:  cfg_reg.jitter_limit  <= cfg_data[JIT_W-1:0];
                REG_REPORT_LIMIT:  cfg_reg.report_limit  <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control, each stage fills when it is empty or moving on
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s2_fire   = s2_valid_reg && out_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg <= raw_x;
            s1_y_reg <= raw_y;
            s1_p_reg <= raw_pressure;
        end
        if (s1_fire)
        begin
            s2_touched_reg <= f_touched;
            s2_x_reg       <= f_x;
            s2_y_reg       <= f_y;
        end
        if (s2_fire)
        begin
            report_valid_reg <= r_report;
            pressed_reg      <= r_pressed;
            pos_x_reg        <= r_x;
            pos_y_reg        <= r_y;
        end
    end

    // touch detect, orientation and jitter filter
    rtc_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_fire),
        .raw_x        (s1_x_reg),
        .raw_y        (s1_y_reg),
        .raw_pressure (s1_p_reg),
        .cfg          (cfg_reg),
        .touched      (f_touched),
        .filt_x       (f_x),
        .filt_y       (f_y)
    );

    // screen scaling and report decision
    rtc_report #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s2_fire),
        .touched      (s2_touched_reg),
        .filt_x       (s2_x_reg),
        .filt_y       (s2_y_reg),
        .cfg          (cfg_reg),
        .report       (r_report),
        .pressed_next (r_pressed),
        .last_x_next  (r_x),
        .last_y_next  (r_y)
    );

    assign out_valid    = out_valid_reg;
    assign report_valid = report_valid_reg;
    assign pressed      = pressed_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;

endmodule

FILE: hdl/rtc_checker.sv
module rtc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      report_valid,
    input logic                      pressed,
    input logic [rtc_pkg::POS_W-1:0] pos_x,
    input logic [rtc_pkg::POS_W-1:0] pos_y
);
    import rtc_pkg::*;

    logic             in_take;
    logic             out_take;
    logic [2:0]       inflight_reg;
    logic [2:0]       inflight_next;
    logic             prev_pressed_reg;
    logic [POS_W-1:0] prev_x_reg;
    logic [POS_W-1:0] prev_y_reg;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // requests taken but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (!in_take && out_take)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    // last delivered state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= '0;
            prev_pressed_reg <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (out_take)
            begin
                prev_pressed_reg <= pressed;
                prev_x_reg       <= pos_x;
                prev_y_reg       <= pos_y;
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(report_valid) && $stable(pressed)
            && $stable(pos_x) && $stable(pos_y))
        else $error("result changed while stalled");

    // no result without an outstanding request, never more than three in flight
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid |-> inflight_reg != 3'd0) && (inflight_reg <= 3'd3))
        else $error("result count does not match requests");

    // a result without a report repeats the state last delivered
    a_no_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !report_valid |-> pressed == prev_pressed_reg
            && pos_x == prev_x_reg && pos_y == prev_y_reg)
        else $error("unreported result changed state");

    // position coordinates are zero together or not at all
    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_x == '0) == (pos_y == '0))
        else $error("one coordinate zero without the other");

endmodule

bind resistive_touch_conditioner_core rtc_checker u_rtc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report_valid (report_valid),
    .pressed      (pressed),
    .pos_x        (pos_x),
    .pos_y        (pos_y)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import rtc_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 100;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [12:0] FULL_SCALE = 13'd1 << SAMPLE_BITS;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct packed {
        logic             report_valid;
        logic             pressed;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } report_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic [11:0]            x;
        logic [11:0]            y;
        logic [11:0]            pz;
        logic                   known;
        report_t                want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [11:0]            raw_x;
    logic [11:0]            raw_y;
    logic [11:0]            raw_pressure;
    logic                   out_valid;
    logic                   out_stall;
    logic                   report_valid;
    logic                   pressed;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;

    // predictor state and register copy
    rtc_cfg_t    cfg_shadow;
    logic [12:0] filt_x;
    logic [12:0] filt_y;
    logic        held_pressed;
    logic [11:0] held_x;
    logic [11:0] held_y;

    report_t     expected_reports[$];
    stim_row_t   stim_rows[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_request;

    resistive_touch_conditioner_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .raw_x(raw_x),
        .raw_y(raw_y),
        .raw_pressure(raw_pressure),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .report_valid(report_valid),
        .pressed(pressed),
        .pos_x(pos_x),
        .pos_y(pos_y)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [12:0] axis_gap(input logic [12:0] a, input logic [12:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // expected report for one accepted sample, advances the predictor state
    function automatic report_t touch_predict(input logic [11:0] sx_raw,
                                              input logic [11:0] sy_raw,
                                              input logic [11:0] pz);
        logic [12:0] sx;
        logic [12:0] sy;
        logic [12:0] tmp;
        logic [13:0] gap_sum;
        logic [24:0] prod_x;
        logic [24:0] prod_y;
        logic [11:0] px;
        logic [11:0] py;
        logic        now;
        logic        fire;
        report_t     r;
        sx = {1'b0, sx_raw};
        sy = {1'b0, sy_raw};
        px = '0;
        py = '0;
        now = (pz > cfg_shadow.pressure_min) && (pz < cfg_shadow.pressure_max);
        if (now)
        begin
            if (cfg_shadow.orientation[ORIENT_MIRROR_X])
                sx = FULL_SCALE - sx;
            if (cfg_shadow.orientation[ORIENT_MIRROR_Y])
                sy = FULL_SCALE - sy;
            if (cfg_shadow.orientation[ORIENT_SWAP])
            begin
                tmp = sx;
                sx = sy;
                sy = tmp;
            end
            // filter only moves past the jitter distance
            gap_sum = 14'(axis_gap(sx, filt_x)) + 14'(axis_gap(sy, filt_y));
            if (gap_sum > {1'b0, cfg_shadow.jitter_limit})
            begin
                filt_x = sx;
                filt_y = sy;
            end
            prod_x = 25'(cfg_shadow.screen_width) * 25'(filt_x);
            prod_y = 25'(cfg_shadow.screen_height) * 25'(filt_y);
            px = prod_x[SAMPLE_BITS +: 12];
            py = prod_y[SAMPLE_BITS +: 12];
        end
        fire = (now != held_pressed)
            || (axis_gap({1'b0, held_x}, {1'b0, px}) > {1'b0, cfg_shadow.report_limit})
            || (axis_gap({1'b0, held_y}, {1'b0, py}) > {1'b0, cfg_shadow.report_limit});
        if (fire)
        begin
            held_pressed = now;
            // a zero coordinate keeps the last position
            if (px != '0 && py != '0)
            begin
                held_x = px;
                held_y = py;
            end
        end
        r.report_valid = fire;
        r.pressed      = held_pressed;
        r.pos_x        = held_x;
        r.pos_y        = held_y;
        return r;
    endfunction

    // idle length, mostly short and now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [11:0] drift(input int v, input int stride);
        int n;
        n = v + int'($urandom_range(0, 2 * stride)) - stride;
        if (n < 0)
            n = 0;
        if (n > 4095)
            n = 4095;
        return n[11:0];
    endfunction

    function automatic logic [11:0] touch_pressure();
        int lo;
        int hi;
        lo = int'(cfg_shadow.pressure_min);
        hi = int'(cfg_shadow.pressure_max);
        if (lo + 1 < hi)
            return 12'($urandom_range(lo + 1, hi - 1));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] lift_pressure();
        int lo;
        int hi;
        lo = int'(cfg_shadow.pressure_min);
        hi = int'(cfg_shadow.pressure_max);
        if ($urandom_range(0, 1) == 0)
            return 12'($urandom_range(0, lo));
        return 12'($urandom_range(hi, 4095));
    endfunction

    // stimulus table builders
    task automatic add_sample(input logic [11:0] x, input logic [11:0] y, input logic [11:0] pz);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.x = x;
        row.y = y;
        row.pz = pz;
        stim_rows.push_back(row);
    endtask

    task automatic add_known(input logic [11:0] x, input logic [11:0] y, input logic [11:0] pz,
                             input logic rv, input logic pr,
                             input logic [11:0] px, input logic [11:0] py);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.x = x;
        row.y = y;
        row.pz = pz;
        row.known = 1'b1;
        row.want = '{rv, pr, px, py};
        stim_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.index = index;
        row.data = data;
        stim_rows.push_back(row);
    endtask

    // one request on the input side, expectation queued at acceptance
    task automatic send_sample(input logic [11:0] x, input logic [11:0] y, input logic [11:0] pz,
                               input logic known, input report_t want);
        report_t predicted;
        int gap;
        raw_x        <= x;
        raw_y        <= y;
        raw_pressure <= pz;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = touch_predict(x, y, pz);
        expected_reports.push_back(known ? want : predicted);
        gap = tx_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding report
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // register write, leaves the write enable up for back-to-back writes
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_SCREEN_WIDTH:  cfg_shadow.screen_width  = data[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: cfg_shadow.screen_height = data[SCREEN_W-1:0];
            REG_ORIENTATION:   cfg_shadow.orientation   = data[ORIENT_W-1:0];
            REG_PRESSURE_MIN:  cfg_shadow.pressure_min  = data[PRESS_W-1:0];
            REG_PRESSURE_MAX:  cfg_shadow.pressure_max  = data[PRESS_W-1:0];
            REG_JITTER_LIMIT:  cfg_shadow.jitter_limit  = data[JIT_W-1:0];
            REG_REPORT_LIMIT:  cfg_shadow.report_limit  = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // register set for one random phase
    task automatic program_phase(input int phase);
        logic [11:0] w;
        logic [11:0] h;
        logic [2:0]  o;
        logic [11:0] pmin;
        logic [11:0] pmax;
        logic [12:0] jit;
        logic [11:0] rl;
        logic        spare;
        logic [9:0]  spare_hi;
        if (phase == 3)
        begin
            // most sensitive corner
            w = 12'd4095; h = 12'd4095; o = 3'd7; pmin = 12'd0; pmax = 12'd4095;
            jit = 13'd0; rl = 12'd0;
        end
        else if (phase == 7)
        begin
            // least sensitive corner
            w = 12'd0; h = 12'd0; o = 3'd0; pmin = 12'd0; pmax = 12'd4095;
            jit = 13'd8191; rl = 12'd4095;
        end
        else
        begin
            w = 12'($urandom_range(0, 4095));
            h = 12'($urandom_range(0, 4095));
            o = 3'($urandom_range(0, 7));
            pmin = 12'($urandom_range(0, 800));
            pmax = 12'($urandom_range(1200, 4095));
            jit = 13'($urandom_range(0, 40));
            rl = 12'($urandom_range(0, 12));
        end
        settle();
        spare = 1'($urandom_range(0, 1));
        write_register(REG_SCREEN_WIDTH, {spare, w});
        spare = 1'($urandom_range(0, 1));
        write_register(REG_SCREEN_HEIGHT, {spare, h});
        spare_hi = 10'($urandom);
        write_register(REG_ORIENTATION, {spare_hi, o});
        spare = 1'($urandom_range(0, 1));
        write_register(REG_PRESSURE_MIN, {spare, pmin});
        spare = 1'($urandom_range(0, 1));
        write_register(REG_PRESSURE_MAX, {spare, pmax});
        write_register(REG_JITTER_LIMIT, jit);
        spare = 1'($urandom_range(0, 1));
        write_register(REG_REPORT_LIMIT, {spare, rl});
        cfg_write <= 1'b0;
    endtask

    // compare one accepted report with the oldest expectation
    task automatic check_report();
        report_t want;
        if (expected_reports.size() == 0)
        begin
            $error("report with no request outstanding");
            mismatch_count++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (report_valid !== want.report_valid)
            begin
                $error("report_valid: expected %0d, got %0d", want.report_valid, report_valid);
                mismatch_count++;
            end
            if (pressed !== want.pressed)
            begin
                $error("pressed: expected %0d, got %0d", want.pressed, pressed);
                mismatch_count++;
            end
            if (pos_x !== want.pos_x)
            begin
                $error("pos_x: expected %0d, got %0d", want.pos_x, pos_x);
                mismatch_count++;
            end
            if (pos_y !== want.pos_y)
            begin
                $error("pos_y: expected %0d, got %0d", want.pos_y, pos_y);
                mismatch_count++;
            end
        end
    endtask

    // receive side: random stalls plus one long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                check_report();
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_stalls && $urandom_range(0, 2) == 0)
                stall_left = idle_length();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // main sequence
    initial
    begin
        int n;
        int len;
        int stride;
        logic [11:0] walk_x;
        logic [11:0] walk_y;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_SCREEN_WIDTH;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        raw_x        <= '0;
        raw_y        <= '0;
        raw_pressure <= '0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        hold_request = 1'b0;

        cfg_shadow.screen_width  = RST_SCREEN_WIDTH;
        cfg_shadow.screen_height = RST_SCREEN_HEIGHT;
        cfg_shadow.orientation   = RST_ORIENTATION;
        cfg_shadow.pressure_min  = RST_PRESSURE_MIN;
        cfg_shadow.pressure_max  = RST_PRESSURE_MAX;
        cfg_shadow.jitter_limit  = RST_JITTER_LIMIT;
        cfg_shadow.report_limit  = RST_REPORT_LIMIT;
        filt_x       = '0;
        filt_y       = '0;
        held_pressed = 1'b0;
        held_x       = '0;
        held_y       = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, reset settings first
        add_known(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 12'd0, 12'd0);
        add_known(12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0, 12'd0, 12'd0);
        add_known(12'd123, 12'd456, 12'd500, 1'b0, 1'b0, 12'd0, 12'd0);
        add_known(12'd123, 12'd456, 12'd2000, 1'b0, 1'b0, 12'd0, 12'd0);
        add_known(12'd4095, 12'd4095, 12'd501, 1'b1, 1'b1, 12'd319, 12'd479);
        add_known(12'd4095, 12'd4095, 12'd1999, 1'b0, 1'b1, 12'd319, 12'd479);
        // small move below jitter, jump to zero, move, move of exactly four
        add_sample(12'd4093, 12'd4094, 12'd1000);
        add_sample(12'd0, 12'd0, 12'd1000);
        add_sample(12'd2048, 12'd1024, 12'd1000);
        add_sample(12'd2050, 12'd1026, 12'd1000);
        // release, then untouched again while last position is far from zero
        add_sample(12'd2048, 12'd1024, 12'd0);
        add_sample(12'd2048, 12'd1024, 12'd0);
        // mirrored zero reading
        add_reg(REG_ORIENTATION, 13'd3);
        add_reg(REG_REPORT_LIMIT, 13'd0);
        add_reg(REG_JITTER_LIMIT, 13'd0);
        add_sample(12'd0, 12'd0, 12'd1000);
        add_sample(12'd4095, 12'd0, 12'd1000);
        // inverted pressure limits
        add_reg(REG_PRESSURE_MIN, 13'd3000);
        add_reg(REG_PRESSURE_MAX, 13'd1000);
        add_reg(REG_ORIENTATION, 13'h1FFF);
        add_sample(12'd100, 12'd100, 12'd2000);
        add_sample(12'd100, 12'd100, 12'd4095);
        add_sample(12'd100, 12'd100, 12'd0);
        // unmapped index and bits above each register width
        add_reg(REG_UNMAPPED, 13'h1FFF);
        add_reg(REG_SCREEN_WIDTH, 13'h1FFF);
        add_reg(REG_SCREEN_HEIGHT, 13'h1000);
        add_reg(REG_PRESSURE_MIN, 13'h1000);
        add_reg(REG_PRESSURE_MAX, 13'h1FFF);
        add_reg(REG_JITTER_LIMIT, 13'h1FFF);
        add_reg(REG_REPORT_LIMIT, 13'h1FFF);
        add_sample(12'd0, 12'd0, 12'd1);
        add_sample(12'd4095, 12'd4095, 12'd4094);
        add_sample(12'd2048, 12'd2048, 12'd4095);

        // walk the table, register writes only once drained
        for (int i = 0; i < stim_rows.size(); i++)
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                if (i == 0 || stim_rows[i-1].kind != ROW_REG)
                    settle();
                write_register(stim_rows[i].index, stim_rows[i].data);
            end
            else
            begin
                if (i > 0 && stim_rows[i-1].kind == ROW_REG)
                    cfg_write <= 1'b0;
                send_sample(stim_rows[i].x, stim_rows[i].y, stim_rows[i].pz,
                            stim_rows[i].known, stim_rows[i].want);
            end
        end

        // random phases: touch strokes with random content, some noise
        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_phase(phase);
            if (phase == 0)
            begin
                tx_gaps = 1'b0;
                rx_stalls = 1'b0;
            end
            else if (phase == 2)
            begin
                tx_gaps = 1'b0;
                rx_stalls = 1'b1;
                hold_request = 1'b1;
            end
            else
            begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095)), 1'b0, '0);
                    n++;
                end
                else
                begin
                    len = $urandom_range(3, 20);
                    stride = $urandom_range(0, 30);
                    walk_x = 12'($urandom_range(0, 4095));
                    walk_y = 12'($urandom_range(0, 4095));
                    repeat (len)
                    begin
                        walk_x = drift(int'(walk_x), stride);
                        walk_y = drift(int'(walk_y), stride);
                        send_sample(walk_x, walk_y, touch_pressure(), 1'b0, '0);
                        n++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                    lift_pressure(), 1'b0, '0);
                        n++;
                    end
                end
            end
        end

        // drain and finish
        rx_stalls = 1'b0;
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
